/* hdl/tild_pkg.sv */
package tild_pkg;

  localparam logic [7:0] LF_BYTE      = 8'h0A;
  localparam logic [7:0] CR_BYTE      = 8'h0D;
  localparam logic [7:0] CARET_BYTE   = 8'h5E;
  localparam logic [7:0] CTRL_LIMIT   = 8'h20;
  localparam logic [7:0] CARET_OFFSET = 8'h40;

  localparam int MODE_ICRNL  = 0;
  localparam int MODE_INLCR  = 1;
  localparam int MODE_CANON  = 2;
  localparam int MODE_ECHO   = 3;
  localparam int MODE_ECHOCTL = 4;
  localparam int MODE_ISIG   = 5;

  localparam logic [5:0] MODE_RESET  = 6'd61;
  localparam logic [7:0] ERASE_RESET = 8'd127;
  localparam logic [7:0] KILL_RESET  = 8'd21;
  localparam logic [7:0] INTR_RESET  = 8'd3;
  localparam logic [7:0] SUSP_RESET  = 8'd26;

  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_ERASE = 3'd1;
  localparam logic [2:0] CFG_KILL  = 3'd2;
  localparam logic [2:0] CFG_INTR  = 3'd3;
  localparam logic [2:0] CFG_SUSP  = 3'd4;

  localparam logic ACT_RECV = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_INTR = 2'd1;
  localparam logic [1:0] SIG_SUSP = 2'd2;

  localparam logic [9:0] COLS_MAX = 10'd1023;

  typedef struct packed {
    logic [5:0] mode_flags;
    logic [7:0] erase_char;
    logic [7:0] kill_char;
    logic [7:0] intr_char;
    logic [7:0] susp_char;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } cmd_t;

  typedef struct packed {
    logic [1:0] echo_count;
    logic [7:0] echo_first;
    logic [7:0] echo_second;
    logic [9:0] erase_columns;
    logic [1:0] signal_raised;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       data_available;
    logic       overflow;
    logic [8:0] buffered_count;
  } res_t;

endpackage

/* hdl/tild_ram.sv */
module tild_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/tild_ctrl.sv */
module tild_ctrl #(
  parameter int BUF_DEPTH = 256,
  parameter int AW        = 8,
  parameter int CW        = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  tild_pkg::cfg_t   cfg,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  tild_pkg::cmd_t   cmd,
  output logic             res_valid,
  input  logic             res_stall,
  output tild_pkg::res_t   res,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [7:0]       wr_data,
  output logic [AW-1:0]    rd_addr,
  input  logic [7:0]       rd_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_POP, ST_RUB, ST_DONE} state_t;

  localparam logic [AW-1:0] LAST_IDX = AW'(BUF_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(BUF_DEPTH);

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    idx_next = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    idx_prev = (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  state_t        state;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;
  logic [CW-1:0] lec;
  logic [AW-1:0] rub_ptr;
  logic          rub_kill;
  logic          handled;
  logic [1:0]    r_ecount;
  logic [7:0]    r_e1;
  logic [7:0]    r_e2;
  logic [9:0]    r_cols;
  logic [1:0]    r_sig;
  logic          r_rvalid;
  logic [7:0]    r_rbyte;
  logic          r_ovf;

  logic          accept;
  logic          canon;
  logic          echo;
  logic          sig_en;
  logic [7:0]    c;
  logic          is_erase;
  logic          is_kill;
  logic          plain;
  logic [1:0]    sig;
  logic [1:0]    ecount;
  logic [7:0]    e1;
  logic [7:0]    e2;
  logic          do_store;
  logic          out_free;
  logic [10:0]   cols_sum;
  logic [9:0]    cols_sat;
  tild_pkg::res_t res_next;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != ST_IDLE);
  assign canon     = cfg.mode_flags[tild_pkg::MODE_CANON];
  assign echo      = cfg.mode_flags[tild_pkg::MODE_ECHO];
  assign sig_en    = cfg.mode_flags[tild_pkg::MODE_ISIG];
  assign out_free  = !res_valid || !res_stall;

  always_comb begin
    if (cmd.in_byte == tild_pkg::CR_BYTE && cfg.mode_flags[tild_pkg::MODE_ICRNL]) begin
      c = tild_pkg::LF_BYTE;
    end else if (cmd.in_byte == tild_pkg::LF_BYTE && cfg.mode_flags[tild_pkg::MODE_INLCR]) begin
      c = tild_pkg::CR_BYTE;
    end else begin
      c = cmd.in_byte;
    end
    is_erase = canon && (c == cfg.erase_char);
    is_kill  = canon && !is_erase && (c == cfg.kill_char);
    plain    = (cmd.action == tild_pkg::ACT_RECV) && !is_erase && !is_kill;

    if (sig_en && c == cfg.intr_char) begin
      sig = tild_pkg::SIG_INTR;
    end else if (sig_en && c == cfg.susp_char) begin
      sig = tild_pkg::SIG_SUSP;
    end else begin
      sig = tild_pkg::SIG_NONE;
    end

    ecount = 2'd0;
    e1     = 8'h00;
    e2     = 8'h00;
    if (echo) begin
      if (c == tild_pkg::LF_BYTE) begin
        ecount = 2'd2;
        e1     = tild_pkg::CR_BYTE;
        e2     = tild_pkg::LF_BYTE;
      end else if (c < tild_pkg::CTRL_LIMIT) begin
        if (cfg.mode_flags[tild_pkg::MODE_ECHOCTL]) begin
          ecount = 2'd2;
          e1     = tild_pkg::CARET_BYTE;
          e2     = c + tild_pkg::CARET_OFFSET;
        end
      end else begin
        ecount = 2'd1;
        e1     = c;
      end
    end

    do_store = plain && (sig == tild_pkg::SIG_NONE) && (count != FULL_CNT);
  end

  // single read port: head for a pop, one behind the tail for rub-out
  always_comb begin
    if (state == ST_RUB) begin
      rd_addr = idx_prev(rub_ptr);
    end else if (cmd.action == tild_pkg::ACT_READ) begin
      rd_addr = head;
    end else begin
      rd_addr = idx_prev(tail);
    end
  end

  assign wr_en   = accept && do_store;
  assign wr_addr = tail;
  assign wr_data = c;

  assign cols_sum = {1'b0, r_cols} + ((rd_data < tild_pkg::CTRL_LIMIT) ? 11'd2 : 11'd1);
  assign cols_sat = (cols_sum > {1'b0, tild_pkg::COLS_MAX}) ? tild_pkg::COLS_MAX
                                                              : cols_sum[9:0];

  always_comb begin
    res_next.echo_count     = r_ecount;
    res_next.echo_first     = r_e1;
    res_next.echo_second    = r_e2;
    res_next.erase_columns  = (handled && echo) ? r_cols : 10'd0;
    res_next.signal_raised  = r_sig;
    res_next.read_valid     = r_rvalid;
    res_next.read_byte      = r_rbyte;
    res_next.data_available = canon ? (lec != '0) : (count != '0);
    res_next.overflow       = r_ovf;
    res_next.buffered_count = 9'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      lec       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            r_ecount <= plain ? ecount : 2'd0;
            r_e1     <= plain ? e1 : 8'h00;
            r_e2     <= plain ? e2 : 8'h00;
            r_cols   <= 10'd0;
            r_sig    <= plain ? sig : tild_pkg::SIG_NONE;
            r_rvalid <= 1'b0;
            r_rbyte  <= 8'h00;
            r_ovf    <= plain && (sig == tild_pkg::SIG_NONE) && (count == FULL_CNT);
            handled  <= (cmd.action == tild_pkg::ACT_RECV) && (is_erase || is_kill);
            rub_kill <= is_kill;
            rub_ptr  <= idx_prev(tail);
            if (cmd.action == tild_pkg::ACT_READ && count != '0) begin
              state <= ST_POP;
            end else if (cmd.action == tild_pkg::ACT_RECV && (is_erase || is_kill)
                         && count != '0) begin
              state <= ST_RUB;
            end else begin
              state <= ST_DONE;
            end
            if (do_store) begin
              tail  <= idx_next(tail);
              count <= count + 1'b1;
              if (c == tild_pkg::LF_BYTE) begin
                lec <= lec + 1'b1;
              end
            end
          end
        end
        ST_POP: begin
          r_rvalid <= 1'b1;
          r_rbyte  <= rd_data;
          head     <= idx_next(head);
          count    <= count - 1'b1;
          if (rd_data == tild_pkg::LF_BYTE && lec != '0) begin
            lec <= lec - 1'b1;
          end
          state <= ST_DONE;
        end
        ST_RUB: begin
          if (rd_data == tild_pkg::LF_BYTE) begin
            state <= ST_DONE;
          end else begin
            tail    <= rub_ptr;
            count   <= count - 1'b1;
            r_cols  <= cols_sat;
            rub_ptr <= idx_prev(rub_ptr);
            if (!rub_kill || count == CW'(1)) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            res   <= res_next;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/tty_input_line_discipline.sv */
// Terminal input line discipline. Each item is either a received byte or a
// read of one buffered byte, and yields exactly one result item. Buffered
// bytes sit in a BUF_DEPTH-byte circular memory with a single registered
// read port; head, tail and counts live in flops. A received byte that is
// stored, dropped or flagged as a signal, an empty read and an empty
// rub-out go straight to the result; a read that pops a byte first passes
// a pop state. An erase or kill walks back one byte per memory read and
// stops at a line end, which it keeps; an erase also stops after one byte,
// a kill when the buffer is empty. The next item can be taken while a
// result waits on res_stall. No memory clearing pass is needed after reset.
module tty_input_line_discipline #(
  parameter int BUF_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [7:0]     cfg_data,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  tild_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output tild_pkg::res_t res
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);

  tild_pkg::cfg_t cfg;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_flags <= tild_pkg::MODE_RESET;
      cfg.erase_char <= tild_pkg::ERASE_RESET;
      cfg.kill_char  <= tild_pkg::KILL_RESET;
      cfg.intr_char  <= tild_pkg::INTR_RESET;
      cfg.susp_char  <= tild_pkg::SUSP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tild_pkg::CFG_MODE:  cfg.mode_flags <= cfg_data[5:0];
        tild_pkg::CFG_ERASE: cfg.erase_char <= cfg_data;
        tild_pkg::CFG_KILL:  cfg.kill_char  <= cfg_data;
        tild_pkg::CFG_INTR:  cfg.intr_char  <= cfg_data;
        tild_pkg::CFG_SUSP:  cfg.susp_char  <= cfg_data;
        default: ;
      endcase
    end
  end

  tild_ram #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tild_ctrl #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

endmodule
